FILE: hw/rtl/pfmt_pkg.sv
// ----------------------------------------------------------------------------
// pfmt_pkg
// Shared constants, microcode word layout and control store for the
// integer formatter sequencer.
// ----------------------------------------------------------------------------
package pfmt_pkg;

   // sizes
   localparam int DIGIT_SLOTS = 22;
   localparam int COUNT_WIDTH = 31;
   localparam int CNT_W       = $clog2(DIGIT_SLOTS + 1);
   localparam int IDX_W       = $clog2(DIGIT_SLOTS);
   localparam int UPC_W       = 4;

   // reciprocal of ten for 32-bit operands: q = (v * RECIP10) >> RECIP_SHIFT
   localparam logic [31:0] RECIP10     = 32'hCCCC_CCCD;
   localparam int          RECIP_SHIFT = 35;

   // conversion codes
   localparam logic [3:0] FN_LIT = 4'd0;
   localparam logic [3:0] FN_D   = 4'd1;
   localparam logic [3:0] FN_U   = 4'd2;
   localparam logic [3:0] FN_O   = 4'd3;
   localparam logic [3:0] FN_XL  = 4'd4;
   localparam logic [3:0] FN_XU  = 4'd5;
   localparam logic [3:0] FN_P   = 4'd6;
   localparam logic [3:0] FN_C   = 4'd7;

   // radix codes
   localparam logic [1:0] RADIX_10 = 2'd0;
   localparam logic [1:0] RADIX_8  = 2'd1;
   localparam logic [1:0] RADIX_16 = 2'd2;

   // datapath operations
   localparam logic [3:0] OP_NOP        = 4'd0;
   localparam logic [3:0] OP_LOAD       = 4'd1;
   localparam logic [3:0] OP_EMIT_CHAR  = 4'd2;
   localparam logic [3:0] OP_EMIT_ZERO  = 4'd3;
   localparam logic [3:0] OP_EMIT_X     = 4'd4;
   localparam logic [3:0] OP_EMIT_MINUS = 4'd5;
   localparam logic [3:0] OP_RECIP      = 4'd6;
   localparam logic [3:0] OP_DIGIT      = 4'd7;
   localparam logic [3:0] OP_READ       = 4'd8;
   localparam logic [3:0] OP_EMIT_DIG   = 4'd9;

   // sequencing conditions
   localparam logic [2:0] CD_ALWAYS   = 3'd0;
   localparam logic [2:0] CD_DISPATCH = 3'd1;
   localparam logic [2:0] CD_IF_NEG   = 3'd2;
   localparam logic [2:0] CD_IF_MORE  = 3'd3;
   localparam logic [2:0] CD_IF_LEFT  = 3'd4;

   // control store addresses
   localparam logic [UPC_W-1:0] UA_IDLE  = 4'd0;
   localparam logic [UPC_W-1:0] UA_CHAR  = 4'd1;
   localparam logic [UPC_W-1:0] UA_PTR0  = 4'd2;
   localparam logic [UPC_W-1:0] UA_PTRX  = 4'd3;
   localparam logic [UPC_W-1:0] UA_SIGN  = 4'd4;
   localparam logic [UPC_W-1:0] UA_MINUS = 4'd5;
   localparam logic [UPC_W-1:0] UA_RECIP = 4'd6;
   localparam logic [UPC_W-1:0] UA_DIGIT = 4'd7;
   localparam logic [UPC_W-1:0] UA_READ  = 4'd8;
   localparam logic [UPC_W-1:0] UA_EMIT  = 4'd9;

   typedef struct packed {
      logic [3:0]       op;
      logic [2:0]       cond;
      logic [UPC_W-1:0] jump;   // taken when the condition holds
      logic [UPC_W-1:0] fall;   // taken otherwise
      logic             last;   // emitted character closes the item
   } uword_type;

   // microprogram
   function automatic uword_type ucode_rom(input logic [UPC_W-1:0] addr);
      uword_type w;
      w = '{op: OP_NOP, cond: CD_ALWAYS, jump: UA_IDLE, fall: UA_IDLE, last: 1'b0};
      case (addr)
         UA_IDLE:  w = '{OP_LOAD,       CD_DISPATCH, UA_IDLE,  UA_IDLE,  1'b0};
         UA_CHAR:  w = '{OP_EMIT_CHAR,  CD_ALWAYS,   UA_IDLE,  UA_IDLE,  1'b1};
         UA_PTR0:  w = '{OP_EMIT_ZERO,  CD_ALWAYS,   UA_PTRX,  UA_PTRX,  1'b0};
         UA_PTRX:  w = '{OP_EMIT_X,     CD_ALWAYS,   UA_RECIP, UA_RECIP, 1'b0};
         UA_SIGN:  w = '{OP_NOP,        CD_IF_NEG,   UA_MINUS, UA_RECIP, 1'b0};
         UA_MINUS: w = '{OP_EMIT_MINUS, CD_ALWAYS,   UA_RECIP, UA_RECIP, 1'b0};
         UA_RECIP: w = '{OP_RECIP,      CD_ALWAYS,   UA_DIGIT, UA_DIGIT, 1'b0};
         UA_DIGIT: w = '{OP_DIGIT,      CD_IF_MORE,  UA_RECIP, UA_READ,  1'b0};
         UA_READ:  w = '{OP_READ,       CD_ALWAYS,   UA_EMIT,  UA_EMIT,  1'b0};
         UA_EMIT:  w = '{OP_EMIT_DIG,   CD_IF_LEFT,  UA_READ,  UA_IDLE,  1'b0};
         default:  w = '{OP_NOP,        CD_ALWAYS,   UA_IDLE,  UA_IDLE,  1'b0};
      endcase
      return w;
   endfunction

   // entry point of each conversion
   function automatic logic [UPC_W-1:0] dispatch_entry(input logic [3:0] func);
      logic [UPC_W-1:0] a;
      case (func)
         FN_LIT, FN_C:              a = UA_CHAR;
         FN_D:                      a = UA_SIGN;
         FN_U, FN_O, FN_XL, FN_XU:  a = UA_RECIP;
         FN_P:                      a = UA_PTR0;
         default:                   a = UA_IDLE;
      endcase
      return a;
   endfunction

   // ascii digit
   function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
      logic [7:0] c;
      if (d < 4'd10) begin
         c = 8'h30 + {4'd0, d};
      end else if (upper) begin
         c = 8'h37 + {4'd0, d};
      end else begin
         c = 8'h57 + {4'd0, d};
      end
      return c;
   endfunction

endpackage

FILE: hw/rtl/printf_integer_formatter_top.sv
// ----------------------------------------------------------------------------
// printf_integer_formatter_top
// Formats one parsed format step per item into a stream of ascii characters.
// ----------------------------------------------------------------------------
// One item is taken at a time. A microcoded sequencer steps through a small
// control store, advancing unless the output register is still full or it
// waits for an item. A literal or %c item is loaded and emitted. A numeric
// conversion generates each digit through the reciprocal multiplier and the
// digit store write, then reads each digit back from the digit store and
// emits it; %d adds a sign test (and a minus sign when the value is negative)
// and %p emits a leading 0x. The longest item is a 16-digit pointer. An
// unknown specifier emits nothing.
module printf_integer_formatter_top
   import pfmt_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [3:0]             req_func,
   input  logic [7:0]             req_literal_char,
   input  logic [63:0]            req_arg_value,
   input  logic                   req_new_call,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [7:0]             rsp_out_char,
   output logic                   rsp_last_char,
   output logic [COUNT_WIDTH-1:0] rsp_chars_so_far
);

   // sequencer and datapath registers
   logic [UPC_W-1:0]       upc_ff, upc_in;
   logic [63:0]            value_ff, value_in;
   logic [28:0]            quot_ff, quot_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [1:0]             radix_ff, radix_in;
   logic                   upper_ff, upper_in;
   logic                   neg_ff, neg_in;
   logic [7:0]             char_ff, char_in;
   logic [3:0]             rd_ff;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [7:0]             rsp_char_ff, rsp_char_in;
   logic                   rsp_last_ff, rsp_last_in;
   logic [COUNT_WIDTH-1:0] rsp_count_ff, rsp_count_in;

   // digit store
   logic [3:0] digit_mem [DIGIT_SLOTS];

   uword_type        uw;
   logic             is_emit;
   logic             stall;
   logic             cond_true;
   logic [31:0]      low32;
   logic [63:0]      prod;
   logic [31:0]      quot10;
   logic [3:0]       digit;
   logic [63:0]      value_next;
   logic [CNT_W-1:0] cnt_inc;
   logic [CNT_W-1:0] cnt_dec;
   logic             wr_en;
   logic [IDX_W-1:0] wr_idx;
   logic [IDX_W-1:0] rd_idx;
   logic [7:0]       emit_char;
   logic             emit_last;

   assign uw = ucode_rom(upc_ff);

   // handshake
   assign is_emit   = (uw.op == OP_EMIT_CHAR) || (uw.op == OP_EMIT_ZERO) ||
                      (uw.op == OP_EMIT_X) || (uw.op == OP_EMIT_MINUS) ||
                      (uw.op == OP_EMIT_DIG);
   assign req_ready = (uw.op == OP_LOAD);
   assign stall     = (is_emit && rsp_valid_ff && !rsp_ready) ||
                      ((uw.op == OP_LOAD) && !req_valid);

   // digit arithmetic
   assign low32   = req_arg_value[31:0];
   assign prod    = value_ff[31:0] * RECIP10;
   assign quot10  = {quot_ff[28:0], 3'b000} + {2'b00, quot_ff[28:0], 1'b0};
   assign cnt_inc = cnt_ff + CNT_W'(1);
   assign cnt_dec = cnt_ff - CNT_W'(1);
   assign wr_idx  = cnt_ff[IDX_W-1:0];
   assign rd_idx  = cnt_dec[IDX_W-1:0];

   always_comb begin
      case (radix_ff)
         RADIX_8: begin
            digit      = {1'b0, value_ff[2:0]};
            value_next = {3'd0, value_ff[63:3]};
         end
         RADIX_16: begin
            digit      = value_ff[3:0];
            value_next = {4'd0, value_ff[63:4]};
         end
         default: begin
            digit      = value_ff[3:0] - quot10[3:0];
            value_next = {35'd0, quot_ff};
         end
      endcase
   end

   // branch condition
   always_comb begin
      case (uw.cond)
         CD_IF_NEG:  cond_true = neg_ff;
         CD_IF_MORE: cond_true = (value_next != 64'd0) && (cnt_inc < CNT_W'(DIGIT_SLOTS));
         CD_IF_LEFT: cond_true = (cnt_ff != '0);
         default:    cond_true = 1'b1;
      endcase
   end

   // character to emit
   always_comb begin
      case (uw.op)
         OP_EMIT_CHAR:  emit_char = char_ff;
         OP_EMIT_ZERO:  emit_char = 8'h30;
         OP_EMIT_X:     emit_char = 8'h78;
         OP_EMIT_MINUS: emit_char = 8'h2D;
         default:       emit_char = digit_char(rd_ff, upper_ff);
      endcase
      emit_last = (uw.op == OP_EMIT_DIG) ? (cnt_ff == '0) : uw.last;
   end

   // next state of sequencer and datapath
   always_comb begin
      upc_in       = upc_ff;
      value_in     = value_ff;
      quot_in      = quot_ff;
      cnt_in       = cnt_ff;
      radix_in     = radix_ff;
      upper_in     = upper_ff;
      neg_in       = neg_ff;
      char_in      = char_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_count_in = rsp_count_ff;
      wr_en        = 1'b0;
      if (!stall) begin
         // step the control store
         if (uw.cond == CD_DISPATCH) begin
            upc_in = dispatch_entry(req_func);
         end else begin
            upc_in = cond_true ? uw.jump : uw.fall;
         end
         case (uw.op)
            OP_LOAD: begin
               neg_in   = (req_func == FN_D) && low32[31];
               upper_in = (req_func == FN_XU);
               char_in  = (req_func == FN_C) ? req_arg_value[7:0] : req_literal_char;
               cnt_in   = '0;
               if (req_func == FN_P) begin
                  value_in = req_arg_value;
               end else if ((req_func == FN_D) && low32[31]) begin
                  value_in = {32'd0, (~low32) + 32'd1};
               end else begin
                  value_in = {32'd0, low32};
               end
               case (req_func)
                  FN_O:               radix_in = RADIX_8;
                  FN_XL, FN_XU, FN_P: radix_in = RADIX_16;
                  default:            radix_in = RADIX_10;
               endcase
               if (req_new_call) begin
                  count_in = '0;
               end
            end
            OP_RECIP: begin
               quot_in = prod[RECIP_SHIFT +: 29];
            end
            OP_DIGIT: begin
               wr_en    = 1'b1;
               value_in = value_next;
               cnt_in   = cnt_inc;
            end
            OP_READ: begin
               cnt_in = cnt_dec;
            end
            OP_EMIT_CHAR, OP_EMIT_ZERO, OP_EMIT_X, OP_EMIT_MINUS, OP_EMIT_DIG: begin
               if (count_ff != '1) begin
                  count_in = count_ff + COUNT_WIDTH'(1);
               end
               rsp_valid_in = 1'b1;
               rsp_char_in  = emit_char;
               rsp_last_in  = emit_last;
               rsp_count_in = count_in;
            end
            default: begin
            end
         endcase
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff       <= UA_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         upc_ff       <= upc_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      value_ff     <= value_in;
      quot_ff      <= quot_in;
      cnt_ff       <= cnt_in;
      radix_ff     <= radix_in;
      upper_ff     <= upper_in;
      neg_ff       <= neg_in;
      char_ff      <= char_in;
      rsp_char_ff  <= rsp_char_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_count_ff <= rsp_count_in;
   end

   // digit store write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         digit_mem[wr_idx] <= digit;
      end
      if ((uw.op == OP_READ) && !stall) begin
         rd_ff <= digit_mem[rd_idx];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_char     = rsp_char_ff;
   assign rsp_last_char    = rsp_last_ff;
   assign rsp_chars_so_far = rsp_count_ff;

endmodule
